// ===== rtl/dcm_pkg.sv =====
// dcm_pkg: shared types and constants of the dc motor pwm drive
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package dcm_pkg;

  localparam int FullScale = 100;
  localparam int PulseW = 12;
  localparam int VelW = 8;
  localparam int MagW = $clog2(FullScale + 1);
  localparam int ProdW = MagW + PulseW;
  localparam int PreW = VelW + 2;

  // reciprocal of the full scale, exact for products below 2**ProdW
  localparam int RecipShift = ProdW + MagW;
  localparam int RecipMul = ((1 << RecipShift) + FullScale - 1) / FullScale;
  localparam int RecipW = RecipShift + 1;

  // reciprocal of three for 12 bit values
  localparam int ThirdShift = 13;
  localparam int ThirdMul = 2731;

  localparam logic [PulseW-1:0] PeriodReset = 12'd2083;
  localparam logic [PulseW-1:0] ThirdReset = 12'd694;

  typedef enum logic [2:0] {
    CMD_SET   = 3'd0,
    CMD_CW    = 3'd1,
    CMD_CCW   = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_BRAKE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_LIM_FWD  = 3'd1,
    REG_LIM_REV  = 3'd2,
    REG_MODE     = 3'd3,
    REG_SWAP     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [PulseW-1:0] period;
    logic [PulseW-1:0] period_third;
    logic [PulseW-1:0] lim_fwd;
    logic [PulseW-1:0] lim_rev;
    logic              two_pwm;
    logic              swap;
  } cfg_t;

  typedef struct packed {
    logic [ProdW-1:0]       product;
    logic signed [VelW-1:0] vel;
    logic                   brake;
  } scale_t;

  typedef struct packed {
    logic [PulseW-1:0]      out1;
    logic [PulseW-1:0]      out2;
    logic signed [VelW-1:0] vel;
    logic                   running;
    dir_e                   dir;
  } result_t;

endpackage

// ===== rtl/dcm_cfg.sv =====
// dcm_cfg: configuration registers, with period/3 kept alongside the period
// depends on dcm_pkg
`timescale 1ns / 1ps

module dcm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [dcm_pkg::PulseW-1:0]  cfg_data_i,
  output dcm_pkg::cfg_t               cfg_o
);
  import dcm_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic [2*PulseW-1:0] third_prod;

  assign third_prod = (2*PulseW)'(cfg_data_i) * (2*PulseW)'(ThirdMul);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_PERIOD: begin
          cfg_d.period = cfg_data_i;
          cfg_d.period_third = PulseW'(third_prod >> ThirdShift);
        end
        REG_LIM_FWD: cfg_d.lim_fwd = cfg_data_i;
        REG_LIM_REV: cfg_d.lim_rev = cfg_data_i;
        REG_MODE:    cfg_d.two_pwm = cfg_data_i[0];
        REG_SWAP:    cfg_d.swap = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= PeriodReset;
      cfg_q.period_third <= ThirdReset;
      cfg_q.lim_fwd <= PeriodReset;
      cfg_q.lim_rev <= PeriodReset;
      cfg_q.two_pwm <= 1'b0;
      cfg_q.swap <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/dcm_vel.sv =====
// dcm_vel: command decode, stored velocity update and width product stage
// depends on dcm_pkg
`timescale 1ns / 1ps

module dcm_vel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dcm_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  cmd_i,
  input  logic [dcm_pkg::VelW-1:0]    speed_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dcm_pkg::scale_t             out_o
);
  import dcm_pkg::*;

  localparam logic signed [PreW-1:0] SatHi = PreW'(FullScale);
  localparam logic signed [PreW-1:0] SatLo = -SatHi;

  logic signed [VelW-1:0] vel_q, vel_d;
  logic                   valid_q;
  scale_t                 data_q;
  logic                   fire;

  logic [VelW-1:0]        stored_abs;
  logic [VelW-1:0]        raw_mag;
  logic signed [PreW-1:0] pre, adj;
  logic signed [VelW-1:0] sat;
  logic                   apply, brake;
  logic [VelW-1:0]        new_abs;
  logic [MagW-1:0]        mag;
  logic [PulseW-1:0]      lim, lim_c;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire = in_valid_i && in_ready_o;

  assign stored_abs = vel_q[VelW-1] ? VelW'(-vel_q) : VelW'(vel_q);

  always_comb begin
    raw_mag = (speed_i == '0) ? stored_abs : speed_i;
    pre = '0;
    apply = 1'b1;
    brake = 1'b0;
    case (cmd_e'(cmd_i))
      CMD_SET:   pre = {{(PreW-VelW){speed_i[VelW-1]}}, speed_i};
      CMD_CW:    pre = {{(PreW-VelW){1'b0}}, raw_mag};
      CMD_CCW:   pre = -$signed({{(PreW-VelW){1'b0}}, raw_mag});
      CMD_STOP:  pre = '0;
      CMD_BRAKE: begin
        apply = 1'b0;
        brake = 1'b1;
      end
      default:   apply = 1'b0;
    endcase
    adj = cfg_i.swap ? -pre : pre;
    if (adj > SatHi) begin
      sat = VelW'(SatHi);
    end else if (adj < SatLo) begin
      sat = VelW'(SatLo);
    end else begin
      sat = VelW'(adj);
    end
    if (brake) begin
      vel_d = '0;
    end else if (apply) begin
      vel_d = sat;
    end else begin
      vel_d = vel_q;
    end
  end

  assign new_abs = vel_d[VelW-1] ? VelW'(-vel_d) : VelW'(vel_d);
  assign mag = MagW'(new_abs);

  always_comb begin
    lim = vel_d[VelW-1] ? cfg_i.lim_rev : cfg_i.lim_fwd;
    if (lim > cfg_i.period) begin
      lim_c = cfg_i.period;
    end else if (lim < cfg_i.period_third) begin
      lim_c = cfg_i.period_third;
    end else begin
      lim_c = lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (fire) begin
        vel_q <= vel_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      data_q.product <= ProdW'(mag) * ProdW'(lim_c);
      data_q.vel <= vel_d;
      data_q.brake <= brake;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o = data_q;

endmodule

// ===== rtl/dcm_drv.sv =====
// dcm_drv: divide by full scale, map width to the bridge inputs, result register
// depends on dcm_pkg
`timescale 1ns / 1ps

module dcm_drv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dcm_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dcm_pkg::scale_t  in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dcm_pkg::result_t out_o
);
  import dcm_pkg::*;

  logic                     valid_q;
  result_t                  res_q, res_d;
  logic [ProdW+RecipW-1:0]  recip_prod;
  logic [PulseW-1:0]        width;
  logic                     fire;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire = in_valid_i && in_ready_o;

  assign recip_prod = (ProdW+RecipW)'(in_i.product) * (ProdW+RecipW)'(RecipMul);
  assign width = PulseW'(recip_prod >> RecipShift);

  always_comb begin
    res_d.vel = in_i.vel;
    res_d.running = (in_i.vel != '0);
    res_d.out1 = '0;
    res_d.out2 = '0;
    res_d.dir = DIR_NONE;
    if (in_i.brake) begin
      if (cfg_i.two_pwm) begin
        res_d.out1 = cfg_i.period;
        res_d.out2 = cfg_i.period;
      end
    end else if (in_i.vel > 0) begin
      res_d.dir = DIR_CW;
      if (cfg_i.two_pwm) begin
        res_d.out2 = width;
      end else begin
        res_d.out1 = width;
        res_d.out2 = cfg_i.period;
      end
    end else if (in_i.vel < 0) begin
      res_d.dir = DIR_CCW;
      res_d.out1 = width;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o = res_q;

endmodule

// ===== rtl/dc_motor_pwm_drive.sv =====
// dc_motor_pwm_drive: h-bridge pwm speed drive, top level with input register
// an accepted beat passes the input, product and result registers on its way to the master side
// throughput: one beat per cycle; input, product and result registers each stall
// only when the stage after them is full and not draining
// reset: configuration returns to period 2083, both limits 2083, direction plus
// pwm mode, no swap; stored velocity is cleared and all stages are emptied
`timescale 1ns / 1ps

module dc_motor_pwm_drive (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // speed[7:0]
  input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out1_pulse[11:0], out2_pulse[23:12],
                                      // velocity[31:24], running[32], direction[34:33]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import dcm_pkg::*;

  cfg_t             cfg;
  logic             in_valid_q;
  logic [2:0]       cmd_q;
  logic [VelW-1:0]  speed_q;
  logic             vel_ready;
  logic             scale_valid, scale_ready;
  scale_t           scale;
  result_t          res;

  assign cfg_ready_o = 1'b1;

  dcm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s_axis_tready = !in_valid_q || vel_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser;
      speed_q <= s_axis_tdata;
    end
  end

  dcm_vel u_vel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (vel_ready),
    .cmd_i       (cmd_q),
    .speed_i     (speed_q),
    .out_valid_o (scale_valid),
    .out_ready_i (scale_ready),
    .out_o       (scale)
  );

  dcm_drv u_drv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (scale_valid),
    .in_ready_o  (scale_ready),
    .in_i        (scale),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {5'b0, res.dir, res.running, res.vel, res.out2, res.out1};

`ifndef SYNTHESIS
  a_running_matches_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.running == (res.vel != '0)))
    else $error("running flag disagrees with velocity");

  a_dir_matches_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((res.dir == DIR_CW) == (res.vel > 0)) &&
                      ((res.dir == DIR_CCW) == (res.vel < 0)))
    else $error("direction disagrees with velocity sign");

  a_vel_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.vel <= VelW'(FullScale)) && (res.vel >= -VelW'(FullScale)))
    else $error("velocity beyond full scale");

  a_stopped_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.running && !cfg.two_pwm |-> (res.out1 == '0) && (res.out2 == '0))
    else $error("pulse driven while stopped");
`endif

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for the dc motor pwm drive, commands in and bridge widths out
// depends on dcm_pkg and dc_motor_pwm_drive; directed table first, then random phases
// each over a different register setting, most with random source gaps, sink stalls or both
`timescale 1ns / 1ps

module tb;
  import dcm_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_e;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] speed;
    bit         lit;
    result_t    res;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  // bench copy of the registers and the stored velocity
  logic [11:0] period_q;
  logic [11:0] lim_fwd_q;
  logic [11:0] lim_rev_q;
  logic        two_pwm_q;
  logic        swap_q;
  int          vel_q;

  result_t     drive_results[$];
  cmd_row_t    cmd_rows[$];
  int          mismatches = 0;
  int          src_pct;
  int          sink_pct;

  dc_motor_pwm_drive i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= sink_pct);
  end

  function automatic int clamp_limit(logic [11:0] lim);
    int lo;
    lo = int'(period_q) / 3;
    if (int'(lim) > int'(period_q)) return int'(period_q);
    if (int'(lim) < lo) return lo;
    return int'(lim);
  endfunction

  function automatic int swap_saturate(int v);
    if (swap_q) v = -v;
    if (v > FullScale) return FullScale;
    if (v < -FullScale) return -FullScale;
    return v;
  endfunction

  function automatic result_t predict_drive(logic [2:0] cmd, logic [7:0] raw);
    result_t r;
    int      mag;
    int      width;
    mag = (vel_q < 0) ? -vel_q : vel_q;
    r = '0;
    case (cmd)
      CMD_SET:   vel_q = swap_saturate(int'($signed(raw)));
      CMD_CW:    vel_q = swap_saturate((raw == 8'd0) ? mag : int'(raw));
      CMD_CCW:   vel_q = swap_saturate((raw == 8'd0) ? -mag : -int'(raw));
      CMD_STOP:  vel_q = swap_saturate(0);
      CMD_BRAKE: vel_q = 0;
      default:   ;
    endcase
    if (cmd == CMD_BRAKE) begin
      r.out1 = two_pwm_q ? period_q : '0;
      r.out2 = two_pwm_q ? period_q : '0;
    end else if (vel_q > 0) begin
      width = vel_q * clamp_limit(lim_fwd_q) / FullScale;
      r.out1 = two_pwm_q ? '0 : width[PulseW-1:0];
      r.out2 = two_pwm_q ? width[PulseW-1:0] : period_q;
    end else if (vel_q < 0) begin
      width = -vel_q * clamp_limit(lim_rev_q) / FullScale;
      r.out1 = width[PulseW-1:0];
      r.out2 = '0;
    end
    r.vel = vel_q[VelW-1:0];
    r.running = (vel_q != 0);
    if (vel_q > 0) r.dir = DIR_CW;
    else if (vel_q < 0) r.dir = DIR_CCW;
    else r.dir = DIR_NONE;
    return r;
  endfunction

  task automatic row_pred(input logic [2:0] cmd, input logic [7:0] speed);
    cmd_row_t row;
    row.cmd = cmd;
    row.speed = speed;
    row.lit = 1'b0;
    row.res = '0;
    cmd_rows.push_back(row);
  endtask

  task automatic row_lit(input logic [2:0] cmd, input logic [7:0] speed,
                         input logic [11:0] out1, input logic [11:0] out2,
                         input logic signed [7:0] vel, input logic running,
                         input dir_e dir);
    cmd_row_t row;
    row.cmd = cmd;
    row.speed = speed;
    row.lit = 1'b1;
    row.res.out1 = out1;
    row.res.out2 = out2;
    row.res.vel = vel;
    row.res.running = running;
    row.res.dir = dir;
    cmd_rows.push_back(row);
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] speed,
                          input bit lit, input result_t lit_res);
    result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < src_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    res = predict_drive(cmd, speed);
    if (lit) res = lit_res;
    drive_results.push_back(res);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = speed;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    case (idx)
      REG_PERIOD:  period_q = data;
      REG_LIM_FWD: lim_fwd_q = data;
      REG_LIM_REV: lim_rev_q = data;
      REG_MODE:    two_pwm_q = data[0];
      REG_SWAP:    swap_q = data[0];
      default:     ;
    endcase
  endtask

  task automatic wait_drained();
    while (drive_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [11:0] period, input logic [11:0] lim_fwd,
                           input logic [11:0] lim_rev, input logic two_pwm,
                           input logic swap, input idle_e idle, input int count);
    logic [2:0] cmd;
    logic [7:0] speed;
    int         sel;
    wait_drained();
    write_reg(REG_PERIOD, period);
    write_reg(REG_LIM_FWD, lim_fwd);
    write_reg(REG_LIM_REV, lim_rev);
    write_reg(REG_MODE, {11'($urandom), two_pwm});
    write_reg(REG_SWAP, {11'($urandom), swap});
    // index past the register list, must be dropped
    write_reg(3'($urandom_range(5, 7)), 12'($urandom));
    src_pct = (idle == IDLE_SRC) ? 58 : (idle == IDLE_BOTH) ? 23 : 0;
    sink_pct = (idle == IDLE_SINK) ? 58 : (idle == IDLE_BOTH) ? 23 : 0;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 8) cmd = 3'($urandom_range(5, 7));
      else cmd = 3'($urandom_range(0, 4));
      sel = $urandom_range(99);
      if (sel < 20) speed = 8'd0;
      else if (sel < 60) speed = 8'($urandom_range(0, 200) - 100);
      else speed = 8'($urandom);
      send_cmd(cmd, speed, 1'b0, '0);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = drive_results.pop_front();
        if (m_axis_tdata[11:0] !== want.out1 || m_axis_tdata[23:12] !== want.out2 ||
            m_axis_tdata[31:24] !== want.vel || m_axis_tdata[32] !== want.running ||
            m_axis_tdata[34:33] !== want.dir) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch exp/act: out1 %0d/%0d out2 %0d/%0d vel %0d/%0d run %0b/%0b dir %0d/%0d",
                     want.out1, m_axis_tdata[11:0], want.out2, m_axis_tdata[23:12],
                     want.vel, $signed(m_axis_tdata[31:24]), want.running,
                     m_axis_tdata[32], want.dir, m_axis_tdata[34:33]);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[dc_motor_pwm_drive] ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    src_pct = 0;
    sink_pct = 0;
    period_q = PeriodReset;
    lim_fwd_q = PeriodReset;
    lim_rev_q = PeriodReset;
    two_pwm_q = 1'b0;
    swap_q = 1'b0;
    vel_q = 0;

    // reset settings: full width 2083, direction plus pwm, no swap
    row_lit(CMD_STOP, 8'h00, 12'd0, 12'd0, 8'sd0, 1'b0, DIR_NONE);
    row_lit(CMD_SET, 8'h7f, 12'd2083, 12'd2083, 8'sd100, 1'b1, DIR_CW);
    row_lit(CMD_SET, 8'h80, 12'd2083, 12'd0, -8'sd100, 1'b1, DIR_CCW);
    row_lit(CMD_SET, 8'h00, 12'd0, 12'd0, 8'sd0, 1'b0, DIR_NONE);
    row_pred(CMD_CW, 8'h00);
    row_pred(CMD_SET, 8'd50);
    row_pred(CMD_CW, 8'h00);
    row_pred(CMD_CCW, 8'h00);
    row_pred(CMD_CW, 8'h01);
    // magnitude with the top bit set saturates
    row_lit(CMD_CCW, 8'hff, 12'd2083, 12'd0, -8'sd100, 1'b1, DIR_CCW);
    row_lit(CMD_CW, 8'h80, 12'd2083, 12'd2083, 8'sd100, 1'b1, DIR_CW);
    row_pred(3'd5, 8'h55);
    row_pred(CMD_SET, 8'hdb);
    row_pred(3'd6, 8'haa);
    row_pred(3'd7, 8'h00);
    row_lit(CMD_BRAKE, 8'h7f, 12'd0, 12'd0, 8'sd0, 1'b0, DIR_NONE);
    row_pred(3'd5, 8'h01);
    row_pred(CMD_SET, 8'h64);
    row_pred(CMD_SET, 8'h9c);
    row_pred(CMD_SET, 8'h65);
    row_pred(CMD_SET, 8'h01);
    row_pred(CMD_CCW, 8'h7f);
    row_pred(CMD_STOP, 8'hff);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (cmd_rows[i]) send_cmd(cmd_rows[i].cmd, cmd_rows[i].speed, cmd_rows[i].lit,
                                   cmd_rows[i].res);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    run_phase(12'd2083, 12'd2083, 12'd2083, 1'b1, 1'b0, IDLE_NONE, 110);
    run_phase(12'd4095, 12'd4095, 12'd0, 1'b0, 1'b1, IDLE_SRC, 110);
    // zero period forces every width to zero
    run_phase(12'd0, 12'd100, 12'd4095, 1'b1, 1'b1, IDLE_SINK, 110);
    run_phase(12'd1, 12'd0, 12'd4095, 1'b0, 1'b0, IDLE_BOTH, 110);
    run_phase(12'd300, 12'd150, 12'd50, 1'b1, 1'b0, IDLE_NONE, 110);
    run_phase(12'($urandom), 12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
              IDLE_BOTH, 110);
    run_phase(12'($urandom), 12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
              IDLE_SRC, 110);
    run_phase(12'($urandom), 12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
              IDLE_SINK, 110);

    wait_drained();
    if (mismatches == 0) begin
      $display("[dc_motor_pwm_drive] OK");
    end else begin
      $display("[dc_motor_pwm_drive] ERROR");
    end
    $finish;
  end

endmodule
